// File: hw/rtl/ntx_pkg.sv
// Package for the aging neighbor table: action and status codes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package ntx_pkg;
  localparam int TableDepth = 32;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int TimeW = 48;
  localparam int EntryW = 32 + 32 + 32 + 4 + 1 + TimeW;

  typedef enum logic [2:0] {
    ACT_TICK = 3'd0, ACT_LOOKUP = 3'd1, ACT_LOOKUP_UP = 3'd2, ACT_ADD = 3'd3,
    ACT_DELETE = 3'd4, ACT_UPDATE = 3'd5, ACT_SET_FLAG = 3'd6, ACT_DEL_IFACE = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_DUPLICATE = 3'd2, ST_FULL = 3'd3,
    ST_DOWN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture input item, clear scan results
    logic rd;        // read slot at scan index
    logic chk;       // evaluate the read slot
    logic step;      // advance scan index
    logic wr;        // finish operation, write memory, make result
  } ntx_cmd_t;

  typedef struct packed {
    logic last;      // scan index is on the final slot
    logic no_scan;   // captured action needs no walk
  } ntx_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/neighbor_table_with_expiry.sv
// Top level of the aging neighbor table: controller plus datapath.
// Depends on ntx_pkg, ntx_ctrl, ntx_dp (and ntx_ram below it).
//
//   channel | direction | handshake          | fields
//   in_     | input     | in_valid/in_stall  | action, key, entry data, lifetime
//   out_    | output    | out_valid/out_stall| status and found entry
//
// A tick skips the walk; every other item walks all 32 slots through the
// single entry memory port, reading and then checking each slot.
// Reset is synchronous and empties the table and zeroes the clock.
// A held result blocks only the final step of the next item.
`default_nettype none
module neighbor_table_with_expiry import ntx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_neighbor_addr,
  input  wire logic [31:0] in_gateway,
  input  wire logic [31:0] in_iface_addr,
  input  wire logic [3:0]  in_device,
  input  wire logic [31:0] in_lifetime,
  input  wire logic        in_entry_flag,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_status,
  output      logic        out_found_flag,
  output      logic [31:0] out_found_gateway,
  output      logic [31:0] out_found_iface,
  output      logic [3:0]  out_found_device,
  output      logic [31:0] out_time_left
);
  ntx_cmd_t cmd;
  ntx_sts_t sts;
  logic res_busy;

  ntx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .res_busy(res_busy), .sts(sts), .cmd(cmd)
  );

  ntx_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .res_busy(res_busy),
    .in_action(in_action), .in_neighbor_addr(in_neighbor_addr),
    .in_gateway(in_gateway), .in_iface_addr(in_iface_addr),
    .in_device(in_device), .in_lifetime(in_lifetime),
    .in_entry_flag(in_entry_flag), .out_valid(out_valid),
    .out_stall(out_stall), .out_status(out_status),
    .out_found_flag(out_found_flag), .out_found_gateway(out_found_gateway),
    .out_found_iface(out_found_iface), .out_found_device(out_found_device),
    .out_time_left(out_time_left)
  );

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd, cmd.chk, cmd.wr})) else $error("command overlap");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !in_stall) else $error("load while stalled");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> out_valid) else $error("result not presented");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_DOWN)) else $error("bad status");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/ntx_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ntx_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/ntx_ctrl.sv
// Controller for the neighbor table: sequences the slot walk.
// Depends on ntx_pkg.
`default_nettype none
module ntx_ctrl import ntx_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire logic     res_busy,
  input  wire ntx_sts_t sts,
  output      ntx_cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD: state_nxt = sts.no_scan ? S_WR : S_CHK;
      S_CHK: state_nxt = sts.last ? S_WR : S_RD;
      S_WR: if (!res_busy) state_nxt = S_IDLE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_RD: cmd.rd = 1'b1;
      S_CHK: begin
        cmd.chk = 1'b1;
        cmd.step = 1'b1;
      end
      S_WR: cmd.wr = !res_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/ntx_dp.sv
// Datapath for the neighbor table: entry memory, used bits, clock,
// slot scan and result register. Depends on ntx_pkg and ntx_ram.
`default_nettype none
module ntx_dp import ntx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ntx_cmd_t    cmd,
  output      ntx_sts_t    sts,
  output      logic        res_busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_neighbor_addr,
  input  wire logic [31:0] in_gateway,
  input  wire logic [31:0] in_iface_addr,
  input  wire logic [3:0]  in_device,
  input  wire logic [31:0] in_lifetime,
  input  wire logic        in_entry_flag,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_status,
  output      logic        out_found_flag,
  output      logic [31:0] out_found_gateway,
  output      logic [31:0] out_found_iface,
  output      logic [3:0]  out_found_device,
  output      logic [31:0] out_time_left
);
  action_t act_r;
  logic [31:0] key_r, gw_r, ifa_r, life_r;
  logic [3:0] dev_r;
  logic flag_r;
  logic [TimeW-1:0] now_r;
  logic [TableDepth-1:0] used_r;
  logic [IdxW-1:0] idx_r;
  logic hit_r, free_r;
  logic [IdxW-1:0] hit_idx_r, free_idx_r;
  logic [EntryW-1:0] hit_ent_r;
  logic valid_r;
  logic [2:0] st_r, st_nxt;
  logic ff_r, ff_nxt;
  logic [31:0] fg_r, fi_r, tl_r;
  logic [31:0] fg_nxt, fi_nxt, tl_nxt;
  logic [3:0] fd_r, fd_nxt;

  logic we;
  logic [IdxW-1:0] addr;
  logic [EntryW-1:0] wdata, rdata;
  logic [31:0] e_key, e_gw, e_ifa;
  logic [3:0] e_dev;
  logic e_up;
  logic [TimeW-1:0] e_exp, new_exp, left;
  logic purge, expired, live, rd_idle;

  assign {e_key, e_gw, e_ifa, e_dev, e_up, e_exp} = rdata;
  assign purge = (act_r == ACT_LOOKUP) || (act_r == ACT_LOOKUP_UP) ||
                 (act_r == ACT_ADD) || (act_r == ACT_DELETE);
  assign expired = purge && (e_exp < now_r);
  assign live = used_r[idx_r] && !expired;
  assign new_exp = now_r + {{(TimeW-32){1'b0}}, life_r};
  assign left = hit_ent_r[TimeW-1:0] - now_r;
  assign rd_idle = 1'b0;

  // Writes at finish: add to the free slot, update/flag on the hit slot.
  always_comb begin
    we = 1'b0;
    addr = idx_r;
    wdata = {key_r, gw_r, ifa_r, dev_r, flag_r, new_exp};
    if (cmd.wr) begin
      if (act_r == ACT_ADD && !hit_r && free_r) begin
        we = 1'b1;
        addr = free_idx_r;
      end else if (act_r == ACT_UPDATE && hit_r) begin
        we = 1'b1;
        addr = hit_idx_r;
        wdata = {hit_ent_r[EntryW-1 -: 32], gw_r, ifa_r, dev_r, flag_r, new_exp};
      end else if (act_r == ACT_SET_FLAG && hit_r) begin
        we = 1'b1;
        addr = hit_idx_r;
        wdata = hit_ent_r;
        wdata[TimeW] = flag_r;
      end
    end
  end

  ntx_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign sts.last = (idx_r == IdxW'(TableDepth - 1));
  assign sts.no_scan = (act_r == ACT_TICK) || rd_idle;
  assign res_busy = valid_r && out_stall;

  // Result fields for the finishing item.
  always_comb begin
    st_nxt = ST_OK;
    ff_nxt = 1'b0;
    fg_nxt = '0;
    fi_nxt = '0;
    fd_nxt = '0;
    tl_nxt = '0;
    unique case (act_r)
      ACT_LOOKUP, ACT_LOOKUP_UP: begin
        if (!hit_r) st_nxt = ST_NOT_FOUND;
        else begin
          ff_nxt = hit_ent_r[TimeW];
          fd_nxt = hit_ent_r[TimeW+4:TimeW+1];
          fi_nxt = hit_ent_r[TimeW+36:TimeW+5];
          fg_nxt = hit_ent_r[TimeW+68:TimeW+37];
          tl_nxt = (left[TimeW-1:32] != '0) ? 32'hFFFF_FFFF : left[31:0];
          if (act_r == ACT_LOOKUP_UP && !hit_ent_r[TimeW]) st_nxt = ST_DOWN;
        end
      end
      ACT_ADD: begin
        if (hit_r) st_nxt = ST_DUPLICATE;
        else if (!free_r) st_nxt = ST_FULL;
      end
      ACT_DELETE, ACT_UPDATE, ACT_SET_FLAG: if (!hit_r) st_nxt = ST_NOT_FOUND;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_action);
      key_r <= in_neighbor_addr;
      gw_r <= in_gateway;
      ifa_r <= in_iface_addr;
      dev_r <= in_device;
      life_r <= in_lifetime;
      flag_r <= in_entry_flag;
    end
    if (cmd.load) begin
      idx_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.chk) begin
      // An expired slot is not live, so it counts as free here.
      if (live && e_key == key_r && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= idx_r;
        hit_ent_r <= rdata;
      end
      if (!live && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (!sts.last) idx_r <= idx_r + IdxW'(1);
    end
    if (cmd.wr) begin
      st_r <= st_nxt;
      ff_r <= ff_nxt;
      fg_r <= fg_nxt;
      fi_r <= fi_nxt;
      fd_r <= fd_nxt;
      tl_r <= tl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      now_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cmd.wr) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
      if (cmd.chk) begin
        if (expired) used_r[idx_r] <= 1'b0;
        if (act_r == ACT_DEL_IFACE && used_r[idx_r] && e_ifa == ifa_r)
          used_r[idx_r] <= 1'b0;
      end
      if (cmd.wr) begin
        if (act_r == ACT_TICK) now_r <= now_r + TimeW'(1);
        if (act_r == ACT_ADD && !hit_r && free_r) used_r[free_idx_r] <= 1'b1;
        if (act_r == ACT_DELETE && hit_r) used_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_status = st_r;
  assign out_found_flag = ff_r;
  assign out_found_gateway = fg_r;
  assign out_found_iface = fi_r;
  assign out_found_device = fd_r;
  assign out_time_left = tl_r;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the aging neighbor table: directed table of items, then random
// traffic, all checked against an in-bench predictor. Depends on ntx_pkg and the RTL.
`default_nettype none
module tb_top;
  import ntx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = TableDepth;
  localparam int NumRandom = 600;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    action_t     act;
    logic [31:0] key;
    logic [31:0] gw;
    logic [31:0] ifa;
    logic [3:0]  dev;
    logic [31:0] life;
    logic        flag;
  } nbr_item_t;

  typedef struct packed {
    status_t     st;
    logic        flag;
    logic [31:0] gw;
    logic [31:0] ifa;
    logic [3:0]  dev;
    logic [31:0] left;
  } nbr_result_t;

  // Directed rows; a typed-in result is used when has_fixed is set.
  typedef struct {
    nbr_item_t   item;
    bit          has_fixed;
    nbr_result_t fixed;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_action;
  logic [31:0] in_neighbor_addr, in_gateway, in_iface_addr, in_lifetime;
  logic [3:0] in_device;
  logic in_entry_flag;
  logic out_valid, out_stall;
  logic [2:0] out_status;
  logic out_found_flag;
  logic [31:0] out_found_gateway, out_found_iface, out_time_left;
  logic [3:0] out_found_device;

  neighbor_table_with_expiry u_top (.*);

  // Predictor state
  bit          tbl_used [Depth];
  logic [31:0] tbl_key [Depth];
  logic [31:0] tbl_gw [Depth];
  logic [31:0] tbl_ifa [Depth];
  logic [3:0]  tbl_dev [Depth];
  logic        tbl_up [Depth];
  logic [47:0] tbl_exp [Depth];
  logic [47:0] clock_now;

  nbr_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit hold_off = 0;
  logic [31:0] known_keys[$];
  logic [31:0] known_ifaces[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic void purge_stale();
    for (int i = 0; i < Depth; i++)
      if (tbl_used[i] && tbl_exp[i] < clock_now) tbl_used[i] = 0;
  endfunction

  function automatic int slot_of(logic [31:0] k);
    for (int i = 0; i < Depth; i++)
      if (tbl_used[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void store_entry(int s, nbr_item_t it);
    tbl_gw[s] = it.gw;
    tbl_ifa[s] = it.ifa;
    tbl_dev[s] = it.dev;
    tbl_exp[s] = clock_now + {16'd0, it.life};
    tbl_up[s] = it.flag;
  endfunction

  function automatic nbr_result_t table_op(nbr_item_t it);
    nbr_result_t r;
    int s;
    logic [47:0] diff;
    r = '{st: ST_OK, flag: 0, gw: 0, ifa: 0, dev: 0, left: 0};
    case (it.act)
      ACT_TICK: clock_now = clock_now + 48'd1;
      ACT_LOOKUP, ACT_LOOKUP_UP: begin
        purge_stale();
        s = slot_of(it.key);
        if (s < 0) r.st = ST_NOT_FOUND;
        else begin
          diff = tbl_exp[s] - clock_now;
          r.left = (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
          r.flag = tbl_up[s];
          r.gw = tbl_gw[s];
          r.ifa = tbl_ifa[s];
          r.dev = tbl_dev[s];
          if (it.act == ACT_LOOKUP_UP && !tbl_up[s]) r.st = ST_DOWN;
        end
      end
      ACT_ADD: begin
        purge_stale();
        if (slot_of(it.key) >= 0) r.st = ST_DUPLICATE;
        else begin
          s = -1;
          for (int i = Depth - 1; i >= 0; i--) if (!tbl_used[i]) s = i;
          if (s < 0) r.st = ST_FULL;
          else begin
            tbl_used[s] = 1;
            tbl_key[s] = it.key;
            store_entry(s, it);
          end
        end
      end
      ACT_DELETE: begin
        purge_stale();
        s = slot_of(it.key);
        if (s < 0) r.st = ST_NOT_FOUND;
        else tbl_used[s] = 0;
      end
      ACT_UPDATE: begin
        s = slot_of(it.key);
        if (s < 0) r.st = ST_NOT_FOUND;
        else store_entry(s, it);
      end
      ACT_SET_FLAG: begin
        s = slot_of(it.key);
        if (s < 0) r.st = ST_NOT_FOUND;
        else tbl_up[s] = it.flag;
      end
      default: begin
        for (int i = 0; i < Depth; i++)
          if (tbl_used[i] && tbl_ifa[i] == it.ifa) tbl_used[i] = 0;
      end
    endcase
    return r;
  endfunction

  function automatic nbr_item_t mk(action_t a, logic [31:0] k, logic [31:0] g,
                                   logic [31:0] f, logic [3:0] d, logic [31:0] l,
                                   logic fl);
    nbr_item_t it;
    it = '{act: a, key: k, gw: g, ifa: f, dev: d, life: l, flag: fl};
    return it;
  endfunction

  function automatic nbr_item_t random_item();
    nbr_item_t it;
    int pick;
    it.act = action_t'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (it.act == ACT_TICK && pick < 50) it.act = ACT_ADD;
    if (known_keys.size() > 0 && pick < 80)
      it.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    else it.key = $urandom();
    it.gw = $urandom();
    if (known_ifaces.size() > 0 && pick % 4 != 0)
      it.ifa = known_ifaces[$urandom_range(0, known_ifaces.size() - 1)];
    else it.ifa = $urandom();
    it.dev = $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0: it.life = $urandom();
      1: it.life = 32'hFFFF_FFFF;
      2: it.life = 0;
      default: it.life = $urandom_range(0, 40);
    endcase
    it.flag = $urandom_range(0, 1);
    if (it.act == ACT_ADD && known_keys.size() < 48) known_keys.push_back(it.key);
    if (known_ifaces.size() < 6) known_ifaces.push_back(it.ifa);
    return it;
  endfunction

  // Valid stays up into the next item when no idle cycles are drawn.
  task automatic send_item(nbr_item_t it);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= it.act;
    in_neighbor_addr <= it.key;
    in_gateway <= it.gw;
    in_iface_addr <= it.ifa;
    in_device <= it.dev;
    in_lifetime <= it.life;
    in_entry_flag <= it.flag;
    do @(posedge clk); while (in_stall);
  endtask

  // Stimulus
  initial begin
    dir_row_t rows[$];
    nbr_result_t zr, r;
    nbr_item_t it;
    zr = '{st: ST_OK, flag: 0, gw: 0, ifa: 0, dev: 0, left: 0};
    in_valid = 0;
    in_action = ACT_TICK;
    in_neighbor_addr = 0;
    in_gateway = 0;
    in_iface_addr = 0;
    in_device = 0;
    in_lifetime = 0;
    in_entry_flag = 0;
    rst_n = 0;
    clock_now = 0;
    foreach (tbl_used[i]) tbl_used[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    r = zr; r.st = ST_NOT_FOUND;
    rows.push_back('{mk(ACT_LOOKUP, 32'h0, 0, 0, 0, 0, 0), 1, r});
    rows.push_back('{mk(ACT_DELETE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1, r});
    rows.push_back('{mk(ACT_UPDATE, 32'h1, 0, 0, 0, 0, 0), 1, r});
    rows.push_back('{mk(ACT_SET_FLAG, 32'h1, 0, 0, 0, 0, 1), 1, r});
    rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0, 0), 1, zr});
    rows.push_back('{mk(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
                        32'hFFFF_FFFF, 1), 1, zr});
    r = zr; r.st = ST_DUPLICATE;
    rows.push_back('{mk(ACT_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1, r});
    rows.push_back('{mk(ACT_LOOKUP_UP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, zr});
    rows.push_back('{mk(ACT_ADD, 32'h0, 32'h1234, 32'hA, 4'h0, 32'd0, 0), 0, zr});
    rows.push_back('{mk(ACT_LOOKUP, 32'h0, 0, 0, 0, 0, 0), 0, zr});
    rows.push_back('{mk(ACT_LOOKUP_UP, 32'h0, 0, 0, 0, 0, 0), 0, zr});
    rows.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0, 0), 0, zr});
    rows.push_back('{mk(ACT_LOOKUP, 32'h0, 0, 0, 0, 0, 0), 0, zr});  // expired
    rows.push_back('{mk(ACT_UPDATE, 32'hFFFF_FFFF, 32'h5, 32'hA, 4'h3, 32'd7, 0), 0, zr});
    rows.push_back('{mk(ACT_SET_FLAG, 32'hFFFF_FFFF, 0, 0, 0, 0, 1), 0, zr});
    rows.push_back('{mk(ACT_LOOKUP_UP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, zr});
    rows.push_back('{mk(ACT_DEL_IFACE, 0, 0, 32'hA, 0, 0, 0), 1, zr});
    rows.push_back('{mk(ACT_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, zr});
    // Fill the table, then one more add hits the full case.
    for (int i = 0; i < Depth; i++)
      rows.push_back('{mk(ACT_ADD, 32'h100 + i, i, 32'hB, i[3:0], 32'hFFFF_FFFF, 1),
                       0, zr});
    r = zr; r.st = ST_FULL;
    rows.push_back('{mk(ACT_ADD, 32'h999, 0, 0, 0, 0, 0), 1, r});
    r = zr; r.st = ST_DUPLICATE;
    rows.push_back('{mk(ACT_ADD, 32'h105, 0, 0, 0, 0, 0), 1, r});
    rows.push_back('{mk(ACT_DELETE, 32'h105, 0, 0, 0, 0, 0), 1, zr});
    rows.push_back('{mk(ACT_DEL_IFACE, 0, 0, 32'hB, 0, 0, 0), 1, zr});

    foreach (rows[i]) begin
      r = table_op(rows[i].item);
      if (rows[i].has_fixed && r != rows[i].fixed) begin
        $display("directed row %0d: typed result disagrees with prediction", i);
        errors++;
      end
      expected_results.push_back(rows[i].has_fixed ? rows[i].fixed : r);
      send_item(rows[i].item);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 200) hold_off = 1;
      it = random_item();
      expected_results.push_back(table_op(it));
      send_item(it);
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // Receiver stall: random per item, plus one long hold-off.
  initial begin
    int gap;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        out_stall <= 1;
        repeat (600) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    nbr_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result, status %0d", out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.st || out_found_flag !== e.flag ||
            out_found_gateway !== e.gw || out_found_iface !== e.ifa ||
            out_found_device !== e.dev || out_time_left !== e.left) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d fl=%0d gw=%h if=%h dev=%0d left=%h",
                     e.st, e.flag, e.gw, e.ifa, e.dev, e.left,
                     " ; got st=%0d fl=%0d gw=%h if=%h dev=%0d left=%h",
                     out_status, out_found_flag, out_found_gateway,
                     out_found_iface, out_found_device, out_time_left);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or delivered result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (stim_done && expected_results.size() == 0) begin
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
          $display("Testbench completed without errors");
        else
          $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
